/* hw/rtl/rlkd_pkg.sv */
package rlkd_pkg;

  localparam int unsigned WindowRegs = 6;
  localparam int unsigned NumWindowsDef = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned KeyW = 8;
  localparam int unsigned SampleW = 10;
  localparam int unsigned CountW = 8;

  typedef enum logic [1:0] {
    ReqTick = 2'd0,
    ReqDone = 2'd1,
    ReqSlot = 2'd2,
    ReqNone = 2'd3
  } req_e;

  localparam logic [CfgIdxW-1:0] RegTickDivisor = 3'd6;

  // Packed as key, upper bound, lower bound (most significant first)
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] hi;
    logic [KeyW-1:0] lo;
  } window_t;

  typedef struct packed {
    logic            hit;
    logic [KeyW-1:0] key;
  } match_t;

  localparam window_t WindowReset [WindowRegs] = '{
    '{key: 8'h00, hi: 8'd255, lo: 8'd233},
    '{key: 8'hea, hi: 8'd93,  lo: 8'd77},
    '{key: 8'hb4, hi: 8'd140, lo: 8'd116},
    '{key: 8'hcd, hi: 8'd195, lo: 8'd163},
    '{key: 8'hb3, hi: 8'd171, lo: 8'd143},
    '{key: 8'he9, hi: 8'd61,  lo: 8'd51}
  };

  localparam logic [CountW-1:0] TickDivisorReset = 8'd15;

endpackage

/* hw/rtl/rlkd_cfg.sv */
module rlkd_cfg #(
  parameter int unsigned NumWin = rlkd_pkg::NumWindowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rlkd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rlkd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output rlkd_pkg::window_t              windows_o [NumWin],
  output logic [rlkd_pkg::CountW-1:0]    tick_divisor_o
);

  rlkd_pkg::window_t               windows_q [NumWin];
  logic [rlkd_pkg::CountW-1:0]     tick_divisor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWin; i++) begin
        windows_q[i] <= rlkd_pkg::WindowReset[i];
      end
      tick_divisor_q <= rlkd_pkg::TickDivisorReset;
    end else if (cfg_we_i) begin
      for (int i = 0; i < NumWin; i++) begin
        if (cfg_idx_i == rlkd_pkg::CfgIdxW'(i)) begin
          windows_q[i] <= rlkd_pkg::window_t'(cfg_wdata_i);
        end
      end
      if (cfg_idx_i == rlkd_pkg::RegTickDivisor) begin
        tick_divisor_q <= cfg_wdata_i[rlkd_pkg::CountW-1:0];
      end
    end
  end

  assign windows_o      = windows_q;
  assign tick_divisor_o = tick_divisor_q;

endmodule

/* hw/rtl/rlkd_match.sv */
module rlkd_match #(
  parameter int unsigned NumWin = rlkd_pkg::NumWindowsDef
) (
  input  rlkd_pkg::window_t          windows_i [NumWin],
  input  logic [rlkd_pkg::KeyW-1:0]  level_i,
  output rlkd_pkg::match_t           match_o
);

  // Walk from the last window down so that the first hit in table order wins
  always_comb begin
    match_o = '0;
    for (int i = NumWin - 1; i >= 0; i--) begin
      if (windows_i[i].lo <= level_i && level_i <= windows_i[i].hi) begin
        match_o.hit = 1'b1;
        match_o.key = windows_i[i].key;
      end
    end
  end

endmodule

/* hw/rtl/resistor_ladder_key_decoder.sv */
// Resistor-ladder keypad decoder. Requests carry a type (timer tick, conversion
// done, report slot) and a 10-bit converter sample; every request yields
// exactly one result with report_valid, report_key and start_conversion. One
// request is taken per clock while the output is not stalled: it passes an
// input register, one stage of window compare and state update, and a result
// register, which holds it while the output is stalled. The windows (up to
// six; key, high, low) and the tick divisor must be written through the plain
// write port only while no request is in flight; the block does not enforce
// this. Windows are searched in index order and the first one containing the
// sample's upper eight bits sets the key.
module resistor_ladder_key_decoder #(
  parameter int unsigned NumWindows = rlkd_pkg::NumWindowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rlkd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rlkd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     req_type_i,
  input  logic [rlkd_pkg::SampleW-1:0]   sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           report_valid_o,
  output logic [rlkd_pkg::KeyW-1:0]      report_key_o,
  output logic                           start_conversion_o
);

  localparam int unsigned NumWin =
      (NumWindows > rlkd_pkg::WindowRegs) ? rlkd_pkg::WindowRegs : NumWindows;

  rlkd_pkg::window_t               windows [NumWin];
  logic [rlkd_pkg::CountW-1:0]     tick_divisor;
  rlkd_pkg::match_t                match;

  // Input register
  logic                            s1_valid_q;
  rlkd_pkg::req_e                  s1_req_q;
  logic [rlkd_pkg::SampleW-1:0]    s1_sample_q;

  // Decoder state
  logic [rlkd_pkg::CountW-1:0]     tick_count_q, tick_count_d;
  logic                            pending_q, pending_d;
  logic [rlkd_pkg::KeyW-1:0]       key_q, key_d;
  logic                            clear_due_q, clear_due_d;

  // Result register
  logic                            out_valid_q;
  logic                            rep_valid_q, rep_valid_d;
  logic [rlkd_pkg::KeyW-1:0]       rep_key_q, rep_key_d;
  logic                            start_q, start_d;

  logic                            advance;
  logic [rlkd_pkg::CountW-1:0]     tick_inc;

  rlkd_cfg #(
    .NumWin (NumWin)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .windows_o      (windows),
    .tick_divisor_o (tick_divisor)
  );

  rlkd_match #(
    .NumWin (NumWin)
  ) u_match (
    .windows_i (windows),
    .level_i   (s1_sample_q[rlkd_pkg::SampleW-1 -: rlkd_pkg::KeyW]),
    .match_o   (match)
  );

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q    <= rlkd_pkg::req_e'(req_type_i);
      s1_sample_q <= sample_i;
    end
  end

  assign tick_inc = tick_count_q + rlkd_pkg::CountW'(1);

  always_comb begin
    tick_count_d = tick_count_q;
    pending_d    = pending_q;
    key_d        = key_q;
    clear_due_d  = clear_due_q;
    rep_valid_d  = 1'b0;
    rep_key_d    = '0;
    start_d      = 1'b0;
    unique case (s1_req_q)
      rlkd_pkg::ReqTick: begin
        tick_count_d = tick_inc;
        if (tick_inc >= tick_divisor) begin
          tick_count_d = '0;
          pending_d    = 1'b1;
          start_d      = 1'b1;
        end
      end
      rlkd_pkg::ReqDone: begin
        if (pending_q) begin
          pending_d = 1'b0;
          if (match.hit) begin
            key_d = match.key;
          end
        end
      end
      rlkd_pkg::ReqSlot: begin
        if (key_q != '0 || clear_due_q) begin
          rep_valid_d = 1'b1;
          rep_key_d   = key_q;
          key_d       = '0;
          clear_due_d = !clear_due_q;
        end
      end
      default: begin
        // unused request code: no state change, result carries nothing
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      pending_q    <= 1'b0;
      key_q        <= '0;
      clear_due_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        tick_count_q <= tick_count_d;
        pending_q    <= pending_d;
        key_q        <= key_d;
        clear_due_q  <= clear_due_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rep_valid_q <= rep_valid_d;
      rep_key_q   <= rep_key_d;
      start_q     <= start_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign report_valid_o     = rep_valid_q;
  assign report_key_o       = rep_key_q;
  assign start_conversion_o = start_q;

endmodule

/* hw/rtl/rlkd_checker.sv */
module rlkd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           report_valid_o,
  input logic [rlkd_pkg::KeyW-1:0]      report_key_o,
  input logic                           start_conversion_o
);

  // A request that reports nothing carries a zero key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !report_valid_o) |-> (report_key_o == '0))
    else $error("key without report");

  // A result never both starts a conversion and reports (only ticks start conversions and only slots report)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && start_conversion_o) |-> !report_valid_o)
    else $error("report and conversion start on one result");

  // An empty result register must not block the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(report_valid_o) && $stable(report_key_o)
       && $stable(start_conversion_o)))
    else $error("stalled result changed");

  // Leaving reset, no result is shown
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result visible straight after reset");

endmodule

bind resistor_ladder_key_decoder rlkd_checker u_rlkd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .report_valid_o     (report_valid_o),
  .report_key_o       (report_key_o),
  .start_conversion_o (start_conversion_o)
);
